[rtl/vdi_pkg.sv]
// shared constants and types of the vertex dedup indexer
`timescale 1ns / 1ps
`default_nettype none

package vdi_pkg;

    // table geometry
    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // payload geometry
    localparam int COORD_W = 32;
    localparam int IDX_W   = 10;
    localparam int ENTRY_W = 3 * COORD_W;

    // result handed from the scan controller to the output stage
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] vertex_index;
        logic             is_new;
        logic             overflow;
    } t_result;

endpackage

`default_nettype wire

[rtl/vdi_if.sv]
// handshake channels of the vertex dedup indexer
`timescale 1ns / 1ps
`default_nettype none

// vertex channel: one word carries three 16.16 coordinates
interface vdi_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [vdi_pkg::COORD_W-1:0] x_coord;
    logic signed [vdi_pkg::COORD_W-1:0] y_coord;
    logic signed [vdi_pkg::COORD_W-1:0] z_coord;

    modport source (output valid, x_coord, y_coord, z_coord, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

// index channel: one word per vertex
interface vdi_out_if;
    logic                        valid;
    logic                        ready;
    logic [vdi_pkg::IDX_W-1:0]   vertex_index;
    logic                        is_new;
    logic                        overflow;

    modport source (output valid, vertex_index, is_new, overflow, input ready);
    modport sink   (input valid, vertex_index, is_new, overflow, output ready);
endinterface

`default_nettype wire

[rtl/vertex_dedup_indexer.sv]
// top level of the vertex dedup indexer
// Each vertex word (three raw 16.16 coordinates) is looked up in a table of up to
// 1024 unique vertices, stored in one memory with one read and one write port.
// The table is scanned in insertion order, one entry per cycle; a match returns
// the stored index, a miss appends the vertex and returns the next index from 0,
// and a miss on a full table returns index 0 with overflow set. With N vertices
// stored, a search reads all N entries when nothing matches and stops early on
// a match. The result sits in an output register, so the next vertex word is
// taken while the previous index waits. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module vertex_dedup_indexer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vdi_in_if.sink    i_vtx,
    vdi_out_if.source o_idx
);

    vdi_pkg::t_result res;
    logic             slot_free;

    logic                        r_out_valid;
    logic [vdi_pkg::IDX_W-1:0]   r_out_index;
    logic                        r_out_new;
    logic                        r_out_ovf;

    vdi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vtx       (i_vtx),
        .i_slot_free (slot_free),
        .o_res       (res)
    );

    assign slot_free = !r_out_valid || o_idx.ready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_idx.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && slot_free) begin
            r_out_index <= res.vertex_index;
            r_out_new   <= res.is_new;
            r_out_ovf   <= res.overflow;
        end
    end

    assign o_idx.valid        = r_out_valid;
    assign o_idx.vertex_index = r_out_index;
    assign o_idx.is_new       = r_out_new;
    assign o_idx.overflow     = r_out_ovf;

endmodule

`default_nettype wire

[rtl/vdi_ram.sv]
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module vdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/vdi_ctrl.sv]
// scan controller: walks the vertex table, appends new vertices
`timescale 1ns / 1ps
`default_nettype none

module vdi_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    vdi_in_if.sink                i_vtx,
    input  wire logic             i_slot_free,
    output vdi_pkg::t_result      o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [vdi_pkg::CNT_W-1:0] FULL_CNT =
        vdi_pkg::CNT_W'(vdi_pkg::MAX_VERTICES);

    logic [1:0]                     r_state, n_state;
    logic [vdi_pkg::ENTRY_W-1:0]    r_key, n_key;
    logic [vdi_pkg::CNT_W-1:0]      r_rd_idx, n_rd_idx;
    logic                           r_cmp_vld, n_cmp_vld;
    logic [vdi_pkg::CNT_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                           r_hit, n_hit;
    logic [vdi_pkg::CNT_W-1:0]      r_hit_idx, n_hit_idx;
    logic [vdi_pkg::CNT_W-1:0]      r_count, n_count;

    logic                           rd_en;
    logic                           wr_en;
    logic                           full;
    logic                           accept;
    logic [vdi_pkg::ENTRY_W-1:0]    rdata;

    // vertex table, one entry holds x, y and z
    vdi_ram #(
        .WIDTH (vdi_pkg::ENTRY_W),
        .DEPTH (vdi_pkg::MAX_VERTICES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[vdi_pkg::ADDR_W-1:0]),
        .i_wdata (r_key),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[vdi_pkg::ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    assign full        = (r_count == FULL_CNT);
    assign i_vtx.ready = (r_state == S_IDLE);
    assign accept      = i_vtx.valid && i_vtx.ready;
    assign rd_en       = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign wr_en       = (r_state == S_DONE) && i_slot_free && !r_hit && !full;

    // result of the finished search
    always_comb begin
        o_res.valid    = (r_state == S_DONE);
        o_res.is_new   = !r_hit && !full;
        o_res.overflow = !r_hit && full;
        if (r_hit) begin
            o_res.vertex_index = vdi_pkg::IDX_W'(r_hit_idx);
        end else if (full) begin
            o_res.vertex_index = '0;
        end else begin
            o_res.vertex_index = vdi_pkg::IDX_W'(r_count);
        end
    end

    // search sequencer: issue one read a cycle, compare each read word in the cycle after
    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_rd_idx  = r_rd_idx;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_count   = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key    = {i_vtx.x_coord, i_vtx.y_coord, i_vtx.z_coord};
                    n_rd_idx = '0;
                    n_hit    = 1'b0;
                    n_state  = (r_count == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx;
                end
                if (r_cmp_vld) begin
                    if (rdata == r_key) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_cmp_idx;
                        n_cmp_vld = 1'b0;
                        n_state   = S_DONE;
                    end else if (r_cmp_idx == r_count - 1'b1) begin
                        n_cmp_vld = 1'b0;
                        n_state   = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                    if (wr_en) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_hit     <= n_hit;
            r_count   <= n_count;
        end
    end

    // search payload
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_hit_idx <= n_hit_idx;
    end

endmodule

`default_nettype wire

[rtl/vdi_checker.sv]
// port-level checks of the vertex dedup indexer
`timescale 1ns / 1ps
`default_nettype none

module vdi_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [vdi_pkg::IDX_W-1:0] i_out_index,
    input wire logic                      i_out_new,
    input wire logic                      i_out_ovf
);

    // no word left over from before reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("index word valid right after reset");

    // a stalled index word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_index) && $stable(i_out_new)
            && $stable(i_out_ovf))
        else $error("index word changed while stalled");

    // appended and overflowed never together
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_new && i_out_ovf))
        else $error("is_new and overflow both set");

    // overflow always reports index zero
    a_ovf_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ovf |-> i_out_index == '0)
        else $error("overflow with nonzero index");

    // one search at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("vertex taken while a search runs");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vtx.valid),
    .i_in_ready  (i_vtx.ready),
    .i_out_valid (o_idx.valid),
    .i_out_ready (o_idx.ready),
    .i_out_index (o_idx.vertex_index),
    .i_out_new   (o_idx.is_new),
    .i_out_ovf   (o_idx.overflow)
);

`default_nettype wire
